// ===== hw/rtl/cpcr_pkg.sv =====
// ----------------------------------------------------------------------------
// cpcr_pkg
// types and widths shared by the circle pair collision resolver
// ----------------------------------------------------------------------------
package cpcr_pkg;

	localparam int COORD_W = 24;
	localparam int RAD_W   = 23;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int SQ_W    = 2 * DIFF_W;
	localparam int ROOT_W  = SQ_W / 2;
	localparam int REM_W   = ROOT_W + 3;
	localparam int RSUM_W  = RAD_W + 1;
	localparam int NUM_W   = RSUM_W + DIFF_W;
	localparam int DEN_W   = ROOT_W + 1;
	localparam int Q_W     = COORD_W - 1;

	localparam logic signed [COORD_W:0] COORD_MAX = (COORD_W + 1)'(2 ** (COORD_W - 1) - 1);
	localparam logic signed [COORD_W:0] COORD_MIN = -(COORD_W + 1)'(2 ** (COORD_W - 1));

	typedef struct packed {
		logic signed [COORD_W-1:0] first_x;
		logic signed [COORD_W-1:0] first_y;
		logic        [RAD_W-1:0]   first_radius;
		logic signed [COORD_W-1:0] second_x;
		logic signed [COORD_W-1:0] second_y;
		logic        [RAD_W-1:0]   second_radius;
	} pair_t;

	typedef struct packed {
		logic                      overlap;
		logic                      coincident;
		logic signed [COORD_W-1:0] new_first_x;
		logic signed [COORD_W-1:0] new_first_y;
		logic signed [COORD_W-1:0] new_second_x;
		logic signed [COORD_W-1:0] new_second_y;
	} result_t;

endpackage

// ===== hw/rtl/cpcr_in_if.sv =====
// ----------------------------------------------------------------------------
// cpcr_in_if
// valid/ready channel carrying one circle pair per transaction
// ----------------------------------------------------------------------------
interface cpcr_in_if;
	logic            valid;
	logic            ready;
	cpcr_pkg::pair_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/cpcr_out_if.sv =====
// ----------------------------------------------------------------------------
// cpcr_out_if
// valid/ready channel carrying one resolved pair per transaction
// ----------------------------------------------------------------------------
interface cpcr_out_if;
	logic              valid;
	logic              ready;
	cpcr_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/circle_pair_collide_resolve_top.sv =====
// ----------------------------------------------------------------------------
// circle_pair_collide_resolve_top
// pipelined overlap test and separation of two circles in Q16.8
// ----------------------------------------------------------------------------
// usage:
//   pairs   : sink channel, one circle pair per transaction
//   results : source channel, one result per pair, in input order
// the center distance is a floor square root resolved one root bit per
// stage (25 stages), the push along the center line a restoring division
// resolving one quotient bit per stage (23 stages, both axes side by side)
// throughput is one pair per cycle; the pipeline advances as a whole
// whenever the output register is empty or being taken, so a stalled
// receiver freezes every stage and nothing is dropped or repeated
// reset clears all stage valid bits; the pipeline is empty and ready
// right after reset
// ----------------------------------------------------------------------------
module circle_pair_collide_resolve_top (
	input  logic        clk,
	input  logic        arst_n,
	cpcr_in_if.sink     pairs,
	cpcr_out_if.source  results
);

	localparam int COORD_W = cpcr_pkg::COORD_W;
	localparam int DIFF_W  = cpcr_pkg::DIFF_W;
	localparam int SQ_W    = cpcr_pkg::SQ_W;
	localparam int ROOT_W  = cpcr_pkg::ROOT_W;
	localparam int REM_W   = cpcr_pkg::REM_W;
	localparam int RSUM_W  = cpcr_pkg::RSUM_W;
	localparam int NUM_W   = cpcr_pkg::NUM_W;
	localparam int DEN_W   = cpcr_pkg::DEN_W;
	localparam int Q_W     = cpcr_pkg::Q_W;

	typedef struct packed {
		logic signed [COORD_W-1:0] x1;
		logic signed [COORD_W-1:0] y1;
		logic signed [COORD_W-1:0] x2;
		logic signed [COORD_W-1:0] y2;
		logic        [RSUM_W-1:0]  rsum;
		logic signed [DIFF_W-1:0]  dx;
		logic signed [DIFF_W-1:0]  dy;
		logic        [DIFF_W-1:0]  adx;
		logic        [DIFF_W-1:0]  ady;
		logic                      ovl;
		logic                      coin;
		logic        [RSUM_W-1:0]  pen;
		logic        [DEN_W-1:0]   den;
	} ctx_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [Q_W-1:0]   low;
		logic [Q_W-1:0]   q;
	} dlane_t;

	function automatic logic signed [COORD_W-1:0] sat_add(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		logic signed [COORD_W:0] s;
		s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
		if (s > cpcr_pkg::COORD_MAX) begin
			return cpcr_pkg::COORD_MAX[COORD_W-1:0];
		end else if (s < cpcr_pkg::COORD_MIN) begin
			return cpcr_pkg::COORD_MIN[COORD_W-1:0];
		end
		return s[COORD_W-1:0];
	endfunction

	logic en;

	logic v_s1, v_s2, v_s3, v_s4, v_s6, v_s7, v_s9;
	ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s6, ctx_s7, ctx_s9;
	ctx_t ctx1_nxt, ctx2_nxt, ctx6_nxt;
	logic [SQ_W-2:0] sqx_s3, sqy_s3;
	logic [SQ_W-1:0] n_s4;
	logic [NUM_W-1:0] numx_s7, numy_s7;
	cpcr_pkg::result_t out_s9;

	assign en           = !v_s9 || results.ready;
	assign pairs.ready  = en;
	assign results.valid = v_s9;
	assign results.data  = out_s9;

	// front end: difference, magnitude, squares, sum
	always_comb begin
		ctx1_nxt      = '0;
		ctx1_nxt.x1   = pairs.data.first_x;
		ctx1_nxt.y1   = pairs.data.first_y;
		ctx1_nxt.x2   = pairs.data.second_x;
		ctx1_nxt.y2   = pairs.data.second_y;
		ctx1_nxt.rsum = RSUM_W'(pairs.data.first_radius) + RSUM_W'(pairs.data.second_radius);
		ctx1_nxt.dx   = DIFF_W'(pairs.data.first_x) - DIFF_W'(pairs.data.second_x);
		ctx1_nxt.dy   = DIFF_W'(pairs.data.first_y) - DIFF_W'(pairs.data.second_y);
	end

	always_comb begin
		ctx2_nxt     = ctx_s1;
		ctx2_nxt.adx = ctx_s1.dx[DIFF_W-1] ? DIFF_W'(-ctx_s1.dx) : DIFF_W'(ctx_s1.dx);
		ctx2_nxt.ady = ctx_s1.dy[DIFF_W-1] ? DIFF_W'(-ctx_s1.dy) : DIFF_W'(ctx_s1.dy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= pairs.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx1_nxt;

			ctx_s2 <= ctx2_nxt;

			ctx_s3 <= ctx_s2;
			sqx_s3 <= (SQ_W - 1)'(ctx_s2.adx * ctx_s2.adx);
			sqy_s3 <= (SQ_W - 1)'(ctx_s2.ady * ctx_s2.ady);

			ctx_s4 <= ctx_s3;
			n_s4   <= SQ_W'(sqx_s3) + SQ_W'(sqy_s3);
		end
	end

	// floor square root, one root bit per stage
	logic                v_s5    [ROOT_W+1];
	ctx_t                ctx_s5  [ROOT_W+1];
	logic [SQ_W-1:0]     n_s5    [ROOT_W+1];
	logic [REM_W-1:0]    rem_s5  [ROOT_W+1];
	logic [ROOT_W-1:0]   root_s5 [ROOT_W+1];

	assign v_s5[0]    = v_s4;
	assign ctx_s5[0]  = ctx_s4;
	assign n_s5[0]    = n_s4;
	assign rem_s5[0]  = '0;
	assign root_s5[0] = '0;

	for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
		logic [REM_W-1:0] rem_w;
		logic [REM_W-1:0] trial;
		logic             ge;

		assign rem_w = {rem_s5[j][REM_W-3:0], n_s5[j][SQ_W-1 -: 2]};
		assign trial = REM_W'({root_s5[j], 2'b01});
		assign ge    = rem_w >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s5[j+1] <= 1'b0;
			end else if (en) begin
				v_s5[j+1] <= v_s5[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s5[j+1]  <= ctx_s5[j];
				n_s5[j+1]    <= {n_s5[j][SQ_W-3:0], 2'b00};
				rem_s5[j+1]  <= ge ? rem_w - trial : rem_w;
				root_s5[j+1] <= {root_s5[j][ROOT_W-2:0], ge};
			end
		end
	end

	// compare, penetration, products
	logic [ROOT_W-1:0] center_dist;
	assign center_dist = root_s5[ROOT_W];

	always_comb begin
		ctx6_nxt      = ctx_s5[ROOT_W];
		ctx6_nxt.ovl  = center_dist < ROOT_W'(ctx_s5[ROOT_W].rsum);
		ctx6_nxt.coin = (center_dist < ROOT_W'(ctx_s5[ROOT_W].rsum)) && (center_dist == '0);
		ctx6_nxt.pen  = ctx_s5[ROOT_W].rsum - center_dist[RSUM_W-1:0];
		ctx6_nxt.den  = {center_dist, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5[ROOT_W];
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s6 <= ctx6_nxt;

			ctx_s7  <= ctx_s6;
			numx_s7 <= NUM_W'(ctx_s6.pen * ctx_s6.adx);
			numy_s7 <= NUM_W'(ctx_s6.pen * ctx_s6.ady);
		end
	end

	// restoring division of both products by twice the distance
	logic   v_s8   [Q_W+1];
	ctx_t   ctx_s8 [Q_W+1];
	dlane_t dx_s8  [Q_W+1];
	dlane_t dy_s8  [Q_W+1];

	assign v_s8[0]   = v_s7;
	assign ctx_s8[0] = ctx_s7;
	assign dx_s8[0]  = '{rem: numx_s7[NUM_W-1 -: DEN_W], low: numx_s7[Q_W-1:0], q: '0};
	assign dy_s8[0]  = '{rem: numy_s7[NUM_W-1 -: DEN_W], low: numy_s7[Q_W-1:0], q: '0};

	for (genvar k = 0; k < Q_W; k++) begin : g_div
		logic [DEN_W:0] tx, ty;
		logic           gex, gey;
		logic [DEN_W:0] subx, suby;

		assign tx   = {dx_s8[k].rem, dx_s8[k].low[Q_W-1]};
		assign ty   = {dy_s8[k].rem, dy_s8[k].low[Q_W-1]};
		assign gex  = tx >= {1'b0, ctx_s8[k].den};
		assign gey  = ty >= {1'b0, ctx_s8[k].den};
		assign subx = tx - {1'b0, ctx_s8[k].den};
		assign suby = ty - {1'b0, ctx_s8[k].den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s8[k+1] <= 1'b0;
			end else if (en) begin
				v_s8[k+1] <= v_s8[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s8[k+1]    <= ctx_s8[k];
				dx_s8[k+1].rem <= gex ? subx[DEN_W-1:0] : tx[DEN_W-1:0];
				dy_s8[k+1].rem <= gey ? suby[DEN_W-1:0] : ty[DEN_W-1:0];
				dx_s8[k+1].low <= {dx_s8[k].low[Q_W-2:0], 1'b0};
				dy_s8[k+1].low <= {dy_s8[k].low[Q_W-2:0], 1'b0};
				dx_s8[k+1].q   <= {dx_s8[k].q[Q_W-2:0], gex};
				dy_s8[k+1].q   <= {dy_s8[k].q[Q_W-2:0], gey};
			end
		end
	end

	// signed shifts and saturated corrected centers
	ctx_t                      ctx_d;
	logic signed [COORD_W-1:0] sx, sy;
	logic                      move;

	assign ctx_d = ctx_s8[Q_W];
	assign sx    = ctx_d.dx[DIFF_W-1] ? -COORD_W'(dx_s8[Q_W].q) : COORD_W'(dx_s8[Q_W].q);
	assign sy    = ctx_d.dy[DIFF_W-1] ? -COORD_W'(dy_s8[Q_W].q) : COORD_W'(dy_s8[Q_W].q);
	assign move  = ctx_d.ovl && !ctx_d.coin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s9            <= ctx_d;
			out_s9.overlap    <= ctx_d.ovl;
			out_s9.coincident <= ctx_d.coin;
			if (move) begin
				out_s9.new_first_x  <= sat_add(ctx_d.x1, sx);
				out_s9.new_first_y  <= sat_add(ctx_d.y1, sy);
				out_s9.new_second_x <= sat_add(ctx_d.x2, -sx);
				out_s9.new_second_y <= sat_add(ctx_d.y2, -sy);
			end else begin
				out_s9.new_first_x  <= ctx_d.x1;
				out_s9.new_first_y  <= ctx_d.y1;
				out_s9.new_second_x <= ctx_d.x2;
				out_s9.new_second_y <= ctx_d.y2;
			end
		end
	end

	// coincident only ever comes with overlap
	a_coin_ovl: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (!results.data.coincident || results.data.overlap))
		else $error("coincident without overlap");

	// a pair that does not overlap leaves its first x and second y where they were
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.data.overlap) |->
		(results.data.new_first_x == ctx_s9.x1 && results.data.new_second_y == ctx_s9.y2))
		else $error("non-overlapping pair moved");

	// a stalled pipeline keeps the valid bits of stage 1 and stage 6
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(v_s1) && $stable(v_s6)))
		else $error("pipeline advanced during stall");

endmodule
